// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/swpt_pkg.sv -----
package swpt_pkg;

	localparam int PEAK_COUNT   = 4;
	localparam int MAX_CHANNELS = 256;

	localparam int CNT_W   = $clog2(MAX_CHANNELS);
	localparam int CHAN_W  = 8;
	localparam int LEVEL_W = 9;
	localparam int FLOOR_W = 17;
	localparam int RANK_W  = (PEAK_COUNT > 1) ? $clog2(PEAK_COUNT) : 1;

	// floor update datapath
	localparam int SUM_W       = FLOOR_W + 4;
	localparam int MAG_W       = SUM_W - 1;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'((2 ** RECIP_SHIFT) / 10);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [LEVEL_W-1:0] level_t;
	typedef logic signed [FLOOR_W-1:0] floor_t;
	typedef logic        [CHAN_W-1:0]  chan_t;

	localparam level_t LEVEL_EMPTY = -LEVEL_W'(200);
	localparam level_t MIN_RESET   = LEVEL_W'(255);
	localparam floor_t FLOOR_RESET = -FLOOR_W'(28160);

	// one finished sweep: ranked table and minimum
	typedef struct packed {
		chan_t  [PEAK_COUNT-1:0] chan;
		level_t [PEAK_COUNT-1:0] lvl;
		logic   [PEAK_COUNT-1:0] occ;
		level_t                  min;
	} sweep_rec_t;

	// record handoff between front, queue and back
	typedef struct packed {
		logic push;
		logic full;
	} rec_wr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} rec_rd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_FIX,
		B_EMIT
	} back_state_t;

endpackage

// ----- rtl/core/swpt_front.sv -----
module swpt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  swpt_pkg::level_t    rssi,
	input  logic                last_in_sweep,
	input  logic                q_full,
	output logic                rec_push,
	output swpt_pkg::sweep_rec_t rec
);
	import swpt_pkg::*;

	logic [CNT_W-1:0]        cnt_q;
	level_t                  min_q;
	chan_t  [PEAK_COUNT-1:0] chan_q;
	level_t [PEAK_COUNT-1:0] lvl_q;
	logic   [PEAK_COUNT-1:0] occ_q;

	logic                    accept;
	logic [PEAK_COUNT-1:0]   gt;
	chan_t                   cur_chan;
	level_t                  min_nx;
	chan_t  [PEAK_COUNT-1:0] chan_nx;
	level_t [PEAK_COUNT-1:0] lvl_nx;
	logic   [PEAK_COUNT-1:0] occ_nx;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign cur_chan = CHAN_W'(cnt_q);
	assign min_nx   = ($signed(rssi) < $signed(min_q)) ? rssi : min_q;

	// table is sorted, so the compare vector is a thermometer
	always_comb begin
		for (int p = 0; p < PEAK_COUNT; p++) begin
			gt[p] = $signed(rssi) > $signed(lvl_q[p]);
		end
		for (int p = 0; p < PEAK_COUNT; p++) begin
			if (p > 0 && gt[(p > 0) ? p - 1 : 0]) begin
				chan_nx[p] = chan_q[(p > 0) ? p - 1 : 0];
				lvl_nx[p]  = lvl_q[(p > 0) ? p - 1 : 0];
				occ_nx[p]  = occ_q[(p > 0) ? p - 1 : 0];
			end else if (gt[p]) begin
				chan_nx[p] = cur_chan;
				lvl_nx[p]  = rssi;
				occ_nx[p]  = 1'b1;
			end else begin
				chan_nx[p] = chan_q[p];
				lvl_nx[p]  = lvl_q[p];
				occ_nx[p]  = occ_q[p];
			end
		end
	end

	assign rec_push = accept && last_in_sweep;
	assign rec.chan = chan_nx;
	assign rec.lvl  = lvl_nx;
	assign rec.occ  = occ_nx;
	assign rec.min  = min_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			min_q  <= MIN_RESET;
			chan_q <= '0;
			lvl_q  <= {PEAK_COUNT{LEVEL_EMPTY}};
			occ_q  <= '0;
		end else if (accept) begin
			if (last_in_sweep) begin
				cnt_q  <= '0;
				min_q  <= MIN_RESET;
				chan_q <= '0;
				lvl_q  <= {PEAK_COUNT{LEVEL_EMPTY}};
				occ_q  <= '0;
			end else begin
				if (cnt_q < CNT_W'(MAX_CHANNELS - 1)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				min_q  <= min_nx;
				chan_q <= chan_nx;
				lvl_q  <= lvl_nx;
				occ_q  <= occ_nx;
			end
		end
	end

endmodule

// ----- rtl/core/swpt_queue.sv -----
module swpt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  swpt_pkg::sweep_rec_t wr_rec,
	output swpt_pkg::rec_wr_t    wr_st,
	input  logic                 pop,
	output swpt_pkg::rec_rd_t    rd_st,
	output swpt_pkg::sweep_rec_t rd_rec
);
	import swpt_pkg::*;

	`include "assert_macros.svh"

	sweep_rec_t          ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign wr_st.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign wr_st.push  = do_push;
	assign rd_st.empty = (cnt_q == '0);
	assign rd_st.pop   = do_pop;
	assign do_push     = push && !wr_st.full;
	assign do_pop      = pop && !rd_st.empty;
	assign rd_rec      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && wr_st.full, "record pushed into full queue")

endmodule

// ----- rtl/core/swpt_back.sv -----
module swpt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swpt_pkg::rec_rd_t    rd_st,
	input  swpt_pkg::sweep_rec_t rec,
	output logic                 rec_pop,
	output logic                 empty,
	input  logic                 pop,
	output swpt_pkg::chan_t      peak_channel,
	output swpt_pkg::level_t     peak_level,
	output logic                 peak_valid,
	output swpt_pkg::floor_t     floor_level,
	output logic                 last_of_run
);
	import swpt_pkg::*;

	`include "assert_macros.svh"

	back_state_t              state_q;
	back_state_t              state_nx;
	logic [RANK_W-1:0]        rank_q;
	floor_t                   floor_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic [FLOOR_W-1:0]       quo_q;

	logic                     out_vld_q;
	chan_t                    out_chan_q;
	level_t                   out_lvl_q;
	logic                     out_occ_q;
	floor_t                   out_floor_q;
	logic                     out_last_q;

	logic                     out_rdy;
	logic                     ld_sum;
	logic                     ld_mul;
	logic                     ld_fix;
	logic                     emit;
	logic                     rank_last;

	logic signed [SUM_W-1:0]  f_x;
	logic signed [SUM_W-1:0]  m_x;
	logic signed [SUM_W-1:0]  sum_nx;
	logic signed [SUM_W-1:0]  sum_abs;
	logic [PROD_W-1:0]        prod;
	logic [SUM_W-1:0]         ten_q;
	logic [SUM_W-1:0]         rem;
	logic [FLOOR_W-1:0]       quo_fix;
	floor_t                   floor_nx;

	assign out_rdy   = !out_vld_q || pop;
	assign rank_last = (rank_q == RANK_W'(PEAK_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ld_sum   = 1'b0;
		ld_mul   = 1'b0;
		ld_fix   = 1'b0;
		emit     = 1'b0;
		rec_pop  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!rd_st.empty) begin
					ld_sum   = 1'b1;
					state_nx = B_MUL;
				end
			end
			B_MUL: begin
				ld_mul   = 1'b1;
				state_nx = B_FIX;
			end
			B_FIX: begin
				ld_fix   = 1'b1;
				state_nx = B_EMIT;
			end
			B_EMIT: begin
				if (out_rdy) begin
					emit = 1'b1;
					if (rank_last) begin
						rec_pop  = 1'b1;
						state_nx = B_IDLE;
					end
				end
			end
			default: begin
				state_nx = B_IDLE;
			end
		endcase
	end

	// 9*floor + 256*min
	assign f_x     = SUM_W'(floor_q);
	assign m_x     = SUM_W'(rec.min);
	assign sum_nx  = (f_x <<< 3) + f_x + (m_x <<< 8);
	assign sum_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;

	// reciprocal estimate is exact or one short
	assign prod     = PROD_W'(mag_q) * PROD_W'(RECIP_TEN);
	assign ten_q    = (SUM_W'(quo_q) << 3) + (SUM_W'(quo_q) << 1);
	assign rem      = SUM_W'(mag_q) - ten_q;
	assign quo_fix  = (rem >= SUM_W'(10)) ? quo_q + 1'b1 : quo_q;
	assign floor_nx = neg_q ? -$signed(quo_fix) : $signed(quo_fix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
			rank_q  <= '0;
		end else begin
			if (ld_fix) begin
				floor_q <= floor_nx;
				rank_q  <= '0;
			end else if (emit) begin
				rank_q <= rank_last ? '0 : rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_sum) begin
			sum_q <= sum_nx;
		end
		if (ld_mul) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= MAG_W'(sum_abs);
			quo_q <= FLOOR_W'(PROD_W'(MAG_W'(sum_abs)) * PROD_W'(RECIP_TEN) >> RECIP_SHIFT);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_occ_q   <= rec.occ[rank_q];
			out_chan_q  <= rec.occ[rank_q] ? rec.chan[rank_q] : '0;
			out_lvl_q   <= rec.occ[rank_q] ? rec.lvl[rank_q] : '0;
			out_floor_q <= floor_q;
			out_last_q  <= rank_last;
		end
	end

	assign empty        = !out_vld_q;
	assign peak_channel = out_chan_q;
	assign peak_level   = out_lvl_q;
	assign peak_valid   = out_occ_q;
	assign floor_level  = out_floor_q;
	assign last_of_run  = out_last_q;

	`ASSERT_ALWAYS(a_rem_small, clk, arst_n, (state_q != B_FIX) || (rem < SUM_W'(20)),
		"reciprocal quotient off by more than one")
	`ASSERT_ALWAYS(a_pop_last, clk, arst_n, rec_pop |-> (emit && rank_last && !rd_st.empty),
		"sweep record released before its last rank")

	// prod feeds the same quotient as the registered path
	`ASSERT_ALWAYS(a_quo_match, clk, arst_n,
		(state_q != B_FIX) || (quo_q == FLOOR_W'(prod >> RECIP_SHIFT)), "quotient path mismatch")

endmodule

// ----- rtl/core/sweep_peak_and_noise_floor_tracker_core.sv -----
// sweep peak and noise floor tracker: takes one rssi sample per channel of a
// frequency sweep, numbers channels from an internal counter that saturates at
// MAX_CHANNELS-1, and keeps the sweep minimum plus a best-first table of the
// PEAK_COUNT strongest samples (strictly above -200 dBm, ties keep the earlier
// channel). the sample flagged last_in_sweep closes the sweep: the noise floor
// becomes (9*floor + 256*min)/10 in 1/256 dBm, truncated toward zero, and
// PEAK_COUNT results come out best rank first, with last_of_run on the final one.
// empty ranks show peak_valid low and zero channel and level. the front ranks a
// sample in the cycle it is accepted, so samples go in at one per cycle while
// full is low. a closed sweep is parked as a record in a two-entry queue; the
// back works out the floor in three steps (sum, reciprocal multiply, correction)
// and then emits the ranks one by one as the output register frees; full rises
// only while both queue entries hold sweeps. no clearing pass is needed after reset
module sweep_peak_and_noise_floor_tracker_core (
	input  logic              clk,
	input  logic              arst_n,
	// sample side
	input  logic              push,
	output logic              full,
	input  swpt_pkg::level_t  rssi,
	input  logic              last_in_sweep,
	// result side
	output logic              empty,
	input  logic              pop,
	output swpt_pkg::chan_t   peak_channel,
	output swpt_pkg::level_t  peak_level,
	output logic              peak_valid,
	output swpt_pkg::floor_t  floor_level,
	output logic              last_of_run
);
	import swpt_pkg::*;

	logic       rec_push;
	logic       rec_pop;
	sweep_rec_t wr_rec;
	sweep_rec_t rd_rec;
	rec_wr_t    wr_st;
	rec_rd_t    rd_st;

	// front: channel counter, running minimum and ranked table, one transaction per cycle while full is low
	swpt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rssi          (rssi),
		.last_in_sweep (last_in_sweep),
		.q_full        (wr_st.full),
		.rec_push      (rec_push),
		.rec           (wr_rec)
	);

	// closed sweeps wait here so the front waits on the result side only when the queue is full
	swpt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wr_rec (wr_rec),
		.wr_st  (wr_st),
		.pop    (rec_pop),
		.rd_st  (rd_st),
		.rd_rec (rd_rec)
	);

	// back: floor update, then one ranked result per cycle into the output register while it is empty or being popped
	swpt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_st        (rd_st),
		.rec          (rd_rec),
		.rec_pop      (rec_pop),
		.empty        (empty),
		.pop          (pop),
		.peak_channel (peak_channel),
		.peak_level   (peak_level),
		.peak_valid   (peak_valid),
		.floor_level  (floor_level),
		.last_of_run  (last_of_run)
	);

endmodule

// ----- verif/tb_sweep_peak_and_noise_floor_tracker_core.sv -----
`timescale 1ns / 1ps

module tb_sweep_peak_and_noise_floor_tracker_core;
	import swpt_pkg::*;

	// cycles without any accepted transaction before the run is abandoned
	localparam int IDLE_LIMIT   = 5000;
	// drain allowance after the last result: four sweeps' worth of back-end work
	localparam int DRAIN_CYCLES = 4 * (PEAK_COUNT + 3);
	localparam int RANDOM_ITEMS = 288;
	localparam int MIN_SWEEPS   = 6;

	// one input transaction
	typedef struct {
		level_t lvl;
		logic   last;
	} sample_t;

	// one ranked result as the block should present it
	typedef struct {
		chan_t  chan;
		level_t lvl;
		logic   valid;
		floor_t flr;
		logic   last;
	} peak_result_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   push = 1'b0;
	logic   full;
	level_t rssi = '0;
	logic   last_in_sweep = 1'b0;
	logic   empty;
	logic   pop = 1'b0;
	chan_t  peak_channel;
	level_t peak_level;
	logic   peak_valid;
	floor_t floor_level;
	logic   last_of_run;

	sweep_peak_and_noise_floor_tracker_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rssi         (rssi),
		.last_in_sweep(last_in_sweep),
		.empty        (empty),
		.pop          (pop),
		.peak_channel (peak_channel),
		.peak_level   (peak_level),
		.peak_valid   (peak_valid),
		.floor_level  (floor_level),
		.last_of_run  (last_of_run)
	);

	always #5 clk = ~clk;

	// stimulus waiting to be driven, and results waiting to be seen
	sample_t      pending_samples[$];
	peak_result_t expected_peaks[$];
	peak_result_t want_peak;
	sample_t      sent;

	int samples_total    = 0;
	int samples_accepted = 0;
	int results_seen     = 0;
	int mismatches       = 0;
	int idle_cycles      = 0;

	// predictor state: the sweep being collected and the running floor
	int     sweep_chan;
	level_t sweep_min;
	int     rank_chan[PEAK_COUNT];
	level_t rank_lvl[PEAK_COUNT];
	bit     rank_occ[PEAK_COUNT];
	floor_t noise_floor;

	// idle control, one set per side
	int drv_gap = 0;
	int drv_stretch = 0;
	bit drv_steady = 1'b0;
	int mon_stall = 0;
	int mon_stretch = 0;
	bit mon_steady = 1'b0;

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch: %s", msg);
	endtask

	// mostly no gap, some short ones, a few long; none in a steady stretch
	function automatic int pick_idle(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic clear_sweep();
		sweep_chan = 0;
		sweep_min  = MIN_RESET;
		for (int k = 0; k < PEAK_COUNT; k++) begin
			rank_chan[k] = 0;
			rank_lvl[k]  = LEVEL_EMPTY;
			rank_occ[k]  = 1'b0;
		end
	endtask

	// fold one accepted sample into the sweep, close it out on the last mark
	task automatic track_sample(input level_t lvl, input logic last);
		int           chan;
		bit           placed;
		int           sum;
		peak_result_t res;
		chan   = sweep_chan;
		placed = 1'b0;
		// counter saturates so an overlong sweep shares the top index
		if (sweep_chan < MAX_CHANNELS - 1)
			sweep_chan++;
		if (lvl < sweep_min)
			sweep_min = lvl;
		// strictly greater: equal levels leave the earlier channel ahead
		for (int p = 0; p < PEAK_COUNT; p++) begin
			if (!placed && lvl > rank_lvl[p]) begin
				for (int q = PEAK_COUNT - 1; q > p; q--) begin
					rank_lvl[q]  = rank_lvl[q-1];
					rank_chan[q] = rank_chan[q-1];
					rank_occ[q]  = rank_occ[q-1];
				end
				rank_lvl[p]  = lvl;
				rank_chan[p] = chan;
				rank_occ[p]  = 1'b1;
				placed       = 1'b1;
			end
		end
		if (last) begin
			// iir on the floor, integer division truncates toward zero
			sum = 9 * int'(noise_floor) + 256 * int'(sweep_min);
			noise_floor = floor_t'(sum / 10);
			for (int k = 0; k < PEAK_COUNT; k++) begin
				res.valid = rank_occ[k];
				// empty rank reads back as zero channel and level
				res.chan  = rank_occ[k] ? chan_t'(rank_chan[k]) : '0;
				res.lvl   = rank_occ[k] ? rank_lvl[k] : '0;
				res.flr   = noise_floor;
				res.last  = (k == PEAK_COUNT - 1);
				expected_peaks.push_back(res);
			end
			clear_sweep();
		end
	endtask

	task automatic add_sample(input int lvl, input bit last);
		sample_t s;
		s.lvl  = level_t'(lvl);
		s.last = last;
		pending_samples.push_back(s);
		samples_total++;
	endtask

	// level mix: full range, the -200 boundary, extremes and a tie-prone set
	function automatic int random_level();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return int'($urandom_range(0, 511)) - 256;
		if (r < 7)
			return int'($urandom_range(0, 6)) - 203;
		if (r == 7) begin
			case ($urandom_range(0, 2))
				0: return -256;
				1: return 255;
				default: return -200;
			endcase
		end
		return int'($urandom_range(0, 3)) * 7 - 20;
	endfunction

	task automatic add_random_sweep(input int len);
		for (int i = 0; i < len; i++)
			add_sample(random_level(), i == len - 1);
	endtask

	// driver: one transaction per accepted edge, hold while full
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				sent = pending_samples.pop_front();
				track_sample(sent.lvl, sent.last);
				samples_accepted++;
			end
			if (!(push && full)) begin
				if (drv_gap > 0) begin
					drv_gap--;
					push <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					push          <= 1'b1;
					rssi          <= pending_samples[0].lvl;
					last_in_sweep <= pending_samples[0].last;
					if (drv_stretch == 0) begin
						drv_stretch = $urandom_range(10, 60);
						drv_steady  = ($urandom_range(0, 2) == 0);
					end
					drv_stretch--;
					drv_gap = pick_idle(drv_steady);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check each popped result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				results_seen++;
				if (expected_peaks.size() == 0) begin
					flag_mismatch($sformatf("result %0d with nothing expected", results_seen));
				end else begin
					want_peak = expected_peaks.pop_front();
					if (peak_channel !== want_peak.chan)
						flag_mismatch($sformatf("result %0d peak_channel %0d, expected %0d",
							results_seen, peak_channel, want_peak.chan));
					if (peak_level !== want_peak.lvl)
						flag_mismatch($sformatf("result %0d peak_level %0d, expected %0d",
							results_seen, peak_level, want_peak.lvl));
					if (peak_valid !== want_peak.valid)
						flag_mismatch($sformatf("result %0d peak_valid %b, expected %b",
							results_seen, peak_valid, want_peak.valid));
					if (floor_level !== want_peak.flr)
						flag_mismatch($sformatf("result %0d floor_level %0d, expected %0d",
							results_seen, floor_level, want_peak.flr));
					if (last_of_run !== want_peak.last)
						flag_mismatch($sformatf("result %0d last_of_run %b, expected %b",
							results_seen, last_of_run, want_peak.last));
				end
				if (mon_stretch == 0) begin
					mon_stretch = $urandom_range(10, 60);
					mon_steady  = ($urandom_range(0, 2) == 0);
				end
				mon_stretch--;
				mon_stall = pick_idle(mon_steady);
			end
			if (mon_stall > 0) begin
				mon_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int random_items;
		int sweeps;
		int long_at;
		int len;
		random_items = 0;
		sweeps       = 0;
		long_at      = $urandom_range(1, 3);
		clear_sweep();
		noise_floor = FLOOR_RESET;

		// single-sample sweep at the top level, minimum stays at its reset value
		add_sample(255, 1'b1);
		// nothing above -200: every rank empty, minimum at the bottom of range
		add_sample(-256, 1'b0);
		add_sample(-200, 1'b1);
		// just above the empty level, a tie, and more peaks than ranks
		add_sample(-199, 1'b0);
		add_sample(10, 1'b0);
		add_sample(10, 1'b0);
		add_sample(5, 1'b0);
		add_sample(20, 1'b0);
		add_sample(-50, 1'b0);
		add_sample(0, 1'b1);
		// ties at the top level with the minimum at the bottom
		add_sample(-1, 1'b0);
		add_sample(255, 1'b0);
		add_sample(-256, 1'b0);
		add_sample(255, 1'b1);
		// rising levels, each new one takes the best rank
		for (int i = 1; i <= 5; i++)
			add_sample(i, i == 5);
		// two negative peaks and one below the empty level
		add_sample(-128, 1'b0);
		add_sample(-129, 1'b0);
		add_sample(-201, 1'b1);

		// random sweeps, one of them long enough to saturate the channel counter
		while (random_items < RANDOM_ITEMS || sweeps < MIN_SWEEPS) begin
			if (sweeps == long_at) begin
				len = $urandom_range(257, 270);
			end else begin
				len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
			end
			add_random_sweep(len);
			random_items += len;
			sweeps++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (samples_accepted == samples_total);
		wait (expected_peaks.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_peaks.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_peaks.size()));
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/swpt_pkg.sv
rtl/core/swpt_front.sv
rtl/core/swpt_queue.sv
rtl/core/swpt_back.sv
rtl/core/sweep_peak_and_noise_floor_tracker_core.sv
verif/tb_sweep_peak_and_noise_floor_tracker_core.sv
